@@ rtl/bzr_pkg.sv @@
package bzr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RESTART = 3'd1,
    PH_HIGH    = 3'd2,
    PH_LOW     = 3'd3,
    PH_WAIT    = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_NOTE   = 2'd1,
    OP_MELODY = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  localparam logic [1:0] REG_NOTE_DURATION = 2'd0;
  localparam logic [1:0] REG_MELODY_STEP   = 2'd1;
  localparam logic [1:0] REG_MELODY_END    = 2'd2;

  localparam logic [15:0] NOTE_DURATION_RST = 16'd800;
  localparam logic [15:0] MELODY_STEP_RST   = 16'd2000;
  localparam logic [3:0]  MELODY_END_RST    = 4'd11;
  localparam logic [3:0]  MELODY_FIRST      = 4'd1;

  typedef struct packed {
    phase_e phase;
    logic   clr_total;
    logic   clr_cycle;
    logic   pin_hi;
    logic   pin_lo;
    logic   advance;
  } bzr_step_t;

  function automatic logic [3:0] half_period(input logic [3:0] p);
    logic [4:0] s;
    s = {1'b0, p} + 5'd1;
    return s[4:1];
  endfunction

endpackage

@@ rtl/buzzer_note_and_melody_generator_core.sv @@
// Output: a result word is registered and is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the next word is taken while a result waits,
// as long as the result register is empty or being drained in the same cycle.
// Reset: asynchronous, active low; both machines idle, pin low, counters zero,
// melody period one, configuration registers at their default values.
module buzzer_note_and_melody_generator_core import bzr_pkg::*; #(
  parameter int TICK_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: tick[0], opcode[2:1], note[6:3], zero fill.
  input  logic [7:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: pin_level[0], note_busy[1], melody_busy[2], zero fill.
  output logic [7:0]  m_tdata
);

  logic [15:0] note_dur_q;
  logic [15:0] mel_step_q;
  logic [3:0]  mel_end_q;

  phase_e                note_phase_q, note_phase_d;
  phase_e                mel_phase_q, mel_phase_d;
  logic [3:0]            note_period_q, note_period_d;
  logic [3:0]            mel_period_q, mel_period_d;
  logic [TICK_WIDTH-1:0] note_cycle_q, note_cycle_d;
  logic [TICK_WIDTH-1:0] note_total_q, note_total_d;
  logic [TICK_WIDTH-1:0] mel_cycle_q, mel_cycle_d;
  logic [TICK_WIDTH-1:0] mel_total_q, mel_total_d;
  logic                  pin_q, pin_d;
  logic                  out_valid_q;
  logic [2:0]            out_data_q;

  logic                  s_fire;
  logic                  tick;
  opcode_e               opcode;
  logic [3:0]            note;
  logic [TICK_WIDTH-1:0] note_cycle_b, note_total_b, mel_cycle_b, mel_total_b;
  bzr_step_t             note_step, mel_step;

  assign s_tready = !out_valid_q || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign tick     = s_tdata[0];
  assign opcode   = opcode_e'(s_tdata[2:1]);
  assign note     = s_tdata[6:3];

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {5'b0, out_data_q};

  function automatic logic [TICK_WIDTH-1:0] bump(input logic [TICK_WIDTH-1:0] c,
                                                input logic t);
    return (t && (c != '1)) ? c + TICK_WIDTH'(1) : c;
  endfunction

  assign note_cycle_b = bump(note_cycle_q, tick);
  assign note_total_b = bump(note_total_q, tick);
  assign mel_cycle_b  = bump(mel_cycle_q, tick);
  assign mel_total_b  = bump(mel_total_q, tick);

  bzr_fsm #(.TICK_WIDTH(TICK_WIDTH)) u_note_fsm (
    .phase_i    (note_phase_q),
    .period_i   (note_period_q),
    .cycle_i    (note_cycle_b),
    .total_i    (note_total_b),
    .duration_i (note_dur_q),
    .last_i     (1'b0),
    .chain_i    (1'b0),
    .step_o     (note_step)
  );

  bzr_fsm #(.TICK_WIDTH(TICK_WIDTH)) u_mel_fsm (
    .phase_i    (mel_phase_q),
    .period_i   (mel_period_q),
    .cycle_i    (mel_cycle_b),
    .total_i    (mel_total_b),
    .duration_i (mel_step_q),
    .last_i     (mel_period_q == mel_end_q),
    .chain_i    (1'b1),
    .step_o     (mel_step)
  );

  always_comb begin
    note_cycle_d  = note_step.clr_cycle ? '0 : note_cycle_b;
    note_total_d  = note_step.clr_total ? '0 : note_total_b;
    mel_cycle_d   = mel_step.clr_cycle ? '0 : mel_cycle_b;
    mel_total_d   = mel_step.clr_total ? '0 : mel_total_b;
    note_phase_d  = note_step.phase;
    mel_phase_d   = mel_step.phase;
    note_period_d = note_period_q;
    mel_period_d  = mel_step.advance ? mel_period_q + 4'd1 : mel_period_q;

    pin_d = pin_q;
    if (note_step.pin_hi) begin
      pin_d = 1'b1;
    end else if (note_step.pin_lo) begin
      pin_d = 1'b0;
    end
    if (mel_step.pin_hi) begin
      pin_d = 1'b1;
    end else if (mel_step.pin_lo) begin
      pin_d = 1'b0;
    end

    case (opcode)
      OP_NOTE: begin
        note_period_d = note;
        note_phase_d  = PH_RESTART;
      end
      OP_MELODY: begin
        mel_period_d = MELODY_FIRST;
        mel_phase_d  = PH_RESTART;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_dur_q <= NOTE_DURATION_RST;
      mel_step_q <= MELODY_STEP_RST;
      mel_end_q  <= MELODY_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NOTE_DURATION: note_dur_q <= cfg_wdata_i;
        REG_MELODY_STEP:   mel_step_q <= cfg_wdata_i;
        REG_MELODY_END:    mel_end_q  <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_phase_q  <= PH_IDLE;
      mel_phase_q   <= PH_IDLE;
      note_period_q <= '0;
      mel_period_q  <= MELODY_FIRST;
      note_cycle_q  <= '0;
      note_total_q  <= '0;
      mel_cycle_q   <= '0;
      mel_total_q   <= '0;
      pin_q         <= 1'b0;
    end else if (s_fire) begin
      note_phase_q  <= note_phase_d;
      mel_phase_q   <= mel_phase_d;
      note_period_q <= note_period_d;
      mel_period_q  <= mel_period_d;
      note_cycle_q  <= note_cycle_d;
      note_total_q  <= note_total_d;
      mel_cycle_q   <= mel_cycle_d;
      mel_total_q   <= mel_total_d;
      pin_q         <= pin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= {mel_phase_d != PH_IDLE, note_phase_d != PH_IDLE, pin_d};
    end
  end

  a_note_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (opcode == OP_NOTE) |=> m_tvalid && m_tdata[1])
    else $error("start note did not report note busy");

  a_mel_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (opcode == OP_MELODY) |=> (mel_period_q == MELODY_FIRST) && m_tdata[2])
    else $error("start melody did not restart at the first period");

  a_busy_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[1] == (note_phase_q != PH_IDLE)) &&
                 (m_tdata[2] == (mel_phase_q != PH_IDLE)))
    else $error("busy flags disagree with machine phases");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_fire |=> $stable(note_total_q) && $stable(mel_total_q) && $stable(pin_q))
    else $error("state changed without an accepted word");

endmodule

@@ rtl/bzr_fsm.sv @@
module bzr_fsm import bzr_pkg::*; #(
  parameter int TICK_WIDTH = 16
) (
  input  phase_e                  phase_i,
  input  logic [3:0]              period_i,
  input  logic [TICK_WIDTH-1:0]   cycle_i,
  input  logic [TICK_WIDTH-1:0]   total_i,
  input  logic [15:0]             duration_i,
  input  logic                    last_i,
  input  logic                    chain_i,
  output bzr_step_t               step_o
);

  localparam int CmpW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

  logic [TICK_WIDTH-1:0] half_ext;
  logic [TICK_WIDTH-1:0] period_ext;
  logic [CmpW-1:0]       total_ext;
  logic [CmpW-1:0]       dur_ext;

  assign half_ext   = {{(TICK_WIDTH-4){1'b0}}, half_period(period_i)};
  assign period_ext = {{(TICK_WIDTH-4){1'b0}}, period_i};
  assign total_ext  = CmpW'(total_i);
  assign dur_ext    = CmpW'(duration_i);

  always_comb begin
    step_o           = '0;
    step_o.phase     = phase_i;
    case (phase_i)
      PH_RESTART: begin
        step_o.clr_total = 1'b1;
        step_o.phase     = PH_HIGH;
      end
      PH_HIGH: begin
        step_o.clr_cycle = 1'b1;
        step_o.pin_hi    = 1'b1;
        step_o.phase     = PH_LOW;
      end
      PH_LOW: begin
        if (cycle_i >= half_ext) begin
          step_o.pin_lo = 1'b1;
          step_o.phase  = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (cycle_i >= period_ext) begin
          step_o.phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (last_i) begin
          step_o.phase = PH_IDLE;
        end else if (total_ext < dur_ext) begin
          step_o.phase = PH_HIGH;
        end else if (chain_i) begin
          step_o.advance = 1'b1;
          step_o.phase   = PH_RESTART;
        end else begin
          step_o.phase = PH_IDLE;
        end
      end
      default: begin
        step_o.phase = phase_i;
      end
    endcase
  end

endmodule

@@ test/bzr_output_checker.sv @@
`timescale 1ns / 100ps

module bzr_output_checker import bzr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  output int          err_cnt_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int MaxShown = 100;

  typedef struct packed {
    logic melody_busy;
    logic note_busy;
    logic pin_level;
  } buzz_out_t;

  logic [15:0] note_dur;
  logic [15:0] mel_step;
  logic [3:0]  mel_end;
  phase_e      note_ph;
  phase_e      mel_ph;
  logic [3:0]  note_per;
  logic [3:0]  mel_per;
  logic [15:0] note_cyc;
  logic [15:0] note_tot;
  logic [15:0] mel_cyc;
  logic [15:0] mel_tot;
  logic        pin;
  buzz_out_t   expected_levels[$];
  buzz_out_t   want;
  buzz_out_t   got;
  int          errs;
  int          checked;

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
    checked_o = 0;
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic logic [15:0] high_ticks(input logic [3:0] p);
    return {13'd0, p[3:1]} + {15'd0, p[0]};
  endfunction

  function automatic buzz_out_t play_pass(input logic tick, input opcode_e op,
                                          input logic [3:0] note);
    buzz_out_t res;
    if (tick) begin
      note_cyc = sat_inc(note_cyc);
      note_tot = sat_inc(note_tot);
      mel_cyc  = sat_inc(mel_cyc);
      mel_tot  = sat_inc(mel_tot);
    end
    case (note_ph)
      PH_RESTART: begin
        note_tot = '0;
        note_ph  = PH_HIGH;
      end
      PH_HIGH: begin
        note_cyc = '0;
        pin      = 1'b1;
        note_ph  = PH_LOW;
      end
      PH_LOW: begin
        if (note_cyc >= high_ticks(note_per)) begin
          pin     = 1'b0;
          note_ph = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (note_cyc >= {12'd0, note_per}) note_ph = PH_CHECK;
      end
      PH_CHECK: begin
        note_ph = (note_tot < note_dur) ? PH_HIGH : PH_IDLE;
      end
      default: ;
    endcase
    case (mel_ph)
      PH_RESTART: begin
        mel_tot = '0;
        mel_ph  = PH_HIGH;
      end
      PH_HIGH: begin
        mel_cyc = '0;
        pin     = 1'b1;
        mel_ph  = PH_LOW;
      end
      PH_LOW: begin
        if (mel_cyc >= high_ticks(mel_per)) begin
          pin    = 1'b0;
          mel_ph = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (mel_cyc >= {12'd0, mel_per}) mel_ph = PH_CHECK;
      end
      PH_CHECK: begin
        if (mel_per == mel_end) begin
          mel_ph = PH_IDLE;
        end else if (mel_tot < mel_step) begin
          mel_ph = PH_HIGH;
        end else begin
          mel_per = mel_per + 4'd1;
          mel_ph  = PH_RESTART;
        end
      end
      default: ;
    endcase
    if (op == OP_NOTE) begin
      note_per = note;
      note_ph  = PH_RESTART;
    end else if (op == OP_MELODY) begin
      mel_per = MELODY_FIRST;
      mel_ph  = PH_RESTART;
    end
    res.pin_level   = pin;
    res.note_busy   = (note_ph != PH_IDLE);
    res.melody_busy = (mel_ph != PH_IDLE);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic exp_v,
                                      input logic act_v);
    if (act_v !== exp_v) begin
      errs++;
      if (errs <= MaxShown) begin
        $display("%0t ns: %s expected %b, got %b", $time, name, exp_v, act_v);
      end
      if (errs == MaxShown) $display("Further mismatches are counted but not shown.");
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_dur = NOTE_DURATION_RST;
      mel_step = MELODY_STEP_RST;
      mel_end  = MELODY_END_RST;
      note_ph  = PH_IDLE;
      mel_ph   = PH_IDLE;
      note_per = '0;
      mel_per  = MELODY_FIRST;
      note_cyc = '0;
      note_tot = '0;
      mel_cyc  = '0;
      mel_tot  = '0;
      pin      = 1'b0;
      expected_levels.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NOTE_DURATION: note_dur = cfg_wdata_i;
          REG_MELODY_STEP:   mel_step = cfg_wdata_i;
          REG_MELODY_END:    mel_end  = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = buzz_out_t'(m_tdata[2:0]);
        if (expected_levels.size() == 0) begin
          errs++;
          $display("%0t ns: result word expected none, got %b", $time, m_tdata);
        end else begin
          want = expected_levels.pop_front();
          checked++;
          check_field("pin_level", want.pin_level, got.pin_level);
          check_field("note_busy", want.note_busy, got.note_busy);
          check_field("melody_busy", want.melody_busy, got.melody_busy);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_levels.push_back(play_pass(s_tdata[0], opcode_e'(s_tdata[2:1]),
                                            s_tdata[6:3]));
      end
      pending_o <= expected_levels.size();
    end
    err_cnt_o <= errs;
    checked_o <= checked;
  end

endmodule

@@ test/tb_buzzer_note_and_melody_generator_core.sv @@
`timescale 1ns / 100ps

module tb_buzzer_note_and_melody_generator_core;
  import bzr_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = REG_NOTE_DURATION;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata     = '0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [7:0]  m_tdata;

  int mismatches;
  int outstanding;
  int results_seen;
  int words_sent   = 0;
  int settings_run = 1;
  int stall_left   = 0;
  bit send_pauses  = 1'b1;
  bit recv_pauses  = 1'b1;

  buzzer_note_and_melody_generator_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  bzr_output_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .err_cnt_o  (mismatches),
    .pending_o  (outstanding),
    .checked_o  (results_seen)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        stall_left = recv_pauses ? $urandom_range(0, 13) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_tready <= (stall_left == 0);
    end
  end

  task automatic push_word(input logic tick, input opcode_e op, input logic [3:0] note);
    int gap;
    gap = send_pauses ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, note, op, tick};
    do @(posedge clk_i); while (!s_tready);
    words_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] dur, input logic [15:0] step,
                              input logic [3:0] stop_at);
    logic [11:0] junk;
    junk = 12'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_NOTE_DURATION;
    cfg_wdata_i <= dur;
    @(posedge clk_i);
    cfg_idx_i   <= REG_MELODY_STEP;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    cfg_idx_i   <= REG_MELODY_END;
    cfg_wdata_i <= {junk, stop_at};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_run++;
  endtask

  task automatic play_random(input int count, input int cmd_pm);
    int r;
    logic tick;
    logic [3:0] note;
    opcode_e op;
    push_word(1'b1, OP_MELODY, 4'($urandom));
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        send_pauses = ($urandom_range(0, 2) != 0);
        recv_pauses = ($urandom_range(0, 2) != 0);
      end
      r    = $urandom_range(0, 999);
      tick = ($urandom_range(0, 3) != 0);
      note = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(13, 15))
                                         : 4'($urandom_range(0, 12));
      if (r < cmd_pm) op = OP_NOTE;
      else if (r < cmd_pm + cmd_pm / 3) op = OP_MELODY;
      else if (r < cmd_pm + cmd_pm / 3 + 10) op = OP_RSVD;
      else op = OP_NONE;
      push_word(tick, op, note);
    end
    wait_drained();
  endtask

  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(1'b0, OP_NONE, 4'd0);
    push_word(1'b1, OP_NONE, 4'd15);
    push_word(1'b1, OP_RSVD, 4'd15);
    push_word(1'b0, OP_RSVD, 4'd0);
    push_word(1'b0, OP_NOTE, 4'd0);
    repeat (4) push_word(1'b1, OP_NONE, 4'd0);
    push_word(1'b1, OP_NOTE, 4'd15);
    repeat (3) push_word(1'b1, OP_NONE, 4'd0);
    push_word(1'b0, OP_NOTE, 4'd13);
    repeat (2) push_word(1'b1, OP_NONE, 4'd0);
    push_word(1'b1, OP_MELODY, 4'd7);
    repeat (3) push_word(1'b1, OP_NONE, 4'd0);
    push_word(1'b0, OP_MELODY, 4'd0);
    repeat (2) push_word(1'b1, OP_NONE, 4'd0);
    push_word(1'b1, OP_NOTE, 4'd12);
    push_word(1'b0, OP_NONE, 4'd0);
    play_random(150, 30);

    program_regs(16'd20, 16'd30, 4'd3);
    play_random(200, 20);

    program_regs(16'd0, 16'd0, 4'd1);
    play_random(150, 60);

    program_regs(16'd0, 16'd0, 4'd0);
    play_random(250, 3);

    program_regs(16'($urandom_range(0, 24)), 16'($urandom_range(0, 24)), 4'd15);
    play_random(150, 10);

    program_regs(16'hFFFF, 16'hFFFF, 4'($urandom_range(1, 15)));
    play_random(100, 30);

    $display("Sent %0d input words under %0d register settings.", words_sent, settings_run);
    $display("Checked %0d result words, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bzr_pkg.sv
rtl/bzr_fsm.sv
rtl/buzzer_note_and_melody_generator_core.sv
test/bzr_output_checker.sv
test/tb_buzzer_note_and_melody_generator_core.sv
